// ----- rtl/core/skt_pkg.sv -----
`default_nettype none

package skt_pkg;

    // table geometry
    localparam int DEPTH     = 64;
    localparam int KEY_WIDTH = 32;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);

    // fixed field widths on the channels
    localparam int CMD_W     = 3;
    localparam int IN_KEY_W  = 32;
    localparam int IN_POS_W  = 6;
    localparam int STATUS_W  = 2;
    localparam int OUT_POS_W = 7;
    localparam int OUT_CNT_W = 7;
    localparam int CFG_IDX_W = 1;

    // wide enough to compare a position field against a count or DEPTH
    localparam int CMP_W = ((CW > IN_POS_W) ? CW : IN_POS_W) + 1;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [AW-1:0]        t_addr;
    typedef logic [CW-1:0]        t_cnt;
    typedef logic [CMP_W-1:0]     t_cmpw;
    typedef logic [OUT_POS_W-1:0] t_out_pos;
    typedef logic [OUT_CNT_W-1:0] t_out_cnt;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT_AT     = 3'd0,
        CMD_SORTED_INSERT = 3'd1,
        CMD_REMOVE        = 3'd2,
        CMD_FIND          = 3'd3,
        CMD_CLEAR         = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SORT_DESC   = 1'b1;

    // comparator verdict on (stored key, probe key)
    typedef struct packed {
        logic eq;
        logic after;
        logic precedes;
    } t_cmp_res;

endpackage

`default_nettype wire

// ----- rtl/core/skt_if.sv -----
`default_nettype none

// command channel
interface skt_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [skt_pkg::CMD_W-1:0]     command;
    logic [skt_pkg::IN_KEY_W-1:0]  key;
    logic [skt_pkg::IN_POS_W-1:0]  position;

    modport source (output valid, command, key, position, input ready);
    modport sink   (input valid, command, key, position, output ready);
endinterface

// response channel
interface skt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [skt_pkg::STATUS_W-1:0]   status;
    logic [skt_pkg::OUT_POS_W-1:0]  result_position;
    logic [skt_pkg::OUT_CNT_W-1:0]  entry_count_out;

    modport source (output valid, status, result_position, entry_count_out, input ready);
    modport sink   (input valid, status, result_position, entry_count_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/skt_ram.sv -----
`default_nettype none

// simple dual-port RAM, registered read
module skt_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  wire logic [P_WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic      [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/skt_cmp.sv -----
`default_nettype none

// shared key comparator, order follows the sort direction
module skt_cmp (
    input  wire logic              i_desc,
    input  wire skt_pkg::t_key     i_a,
    input  wire skt_pkg::t_key     i_b,
    output skt_pkg::t_cmp_res      o_res
);

    logic lt;
    logic gt;

    assign lt = (i_a < i_b);
    assign gt = (i_a > i_b);

    assign o_res.eq       = (i_a == i_b);
    assign o_res.after    = i_desc ? lt : gt;
    assign o_res.precedes = i_desc ? gt : lt;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_key_table_top.sv -----
// Sorted key table: up to DEPTH keys in one RAM plus an entry count.
// i_cmd (sink) takes one command transaction: insert at position, sorted
// insert, remove, find or clear. o_rsp (source) returns one response per
// command: status, position and the entry count after the command.
// i_cfg_we/i_cfg_idx/i_cfg_data write search_mode (0) and sort_descending (1);
// write only while no command is in flight.
// One command at a time: i_cmd.ready is high only while the sequencer idles.
// Clear, error statuses and unknown codes go directly to the response state.
// Sorted insert first scans for the first later key; both inserts then shift
// the keys at and past the position up and write the new key into the gap,
// or append past the end. Remove shifts the later keys down. Find scans in
// order, or with search_mode set checks both bounds and then halves the range.
// The rate is set by the single RAM port pair: one key read and one key
// write per cycle, all compares through one shared comparator.
// Reset clears the count, the config and the sequencer; RAM contents are
// not cleared and are never read beyond the count.
// A stalled receiver holds the response register; a new command may be
// accepted meanwhile, and its response waits until the register frees.
`default_nettype none

module sorted_key_table_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    skt_cmd_if.sink                                i_cmd,
    skt_rsp_if.source                              o_rsp,
    input  wire logic                              i_cfg_we,
    input  wire logic [skt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic                              i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_BIN   = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // binary search sub-steps: bound checks, then the halving loop
    typedef enum logic [2:0] {
        BP_FIRST = 3'b001,
        BP_LAST  = 3'b010,
        BP_LOOP  = 3'b100
    } t_bphase;

    // control
    t_state               r_state,  n_state;
    skt_pkg::t_cnt        r_count,  n_count;
    logic                 r_out_valid, n_out_valid;
    logic                 r_rd_valid,  n_rd_valid;
    logic                 r_search_mode, n_search_mode;
    logic                 r_sort_desc,   n_sort_desc;

    // working registers
    logic [skt_pkg::CMD_W-1:0] r_cmd, n_cmd;
    skt_pkg::t_key        r_key,    n_key;
    skt_pkg::t_cnt        r_idx,    n_idx;
    skt_pkg::t_cnt        r_rd_idx, n_rd_idx;
    skt_pkg::t_cnt        r_where,  n_where;
    skt_pkg::t_cnt        r_lo,     n_lo;
    skt_pkg::t_cnt        r_hiex,   n_hiex;      // exclusive upper bound
    skt_pkg::t_status     r_status, n_status;
    t_bphase              r_bphase, n_bphase;
    logic                 r_up,     n_up;        // shift direction
    logic                 r_issue_done, n_issue_done;

    // response register
    skt_pkg::t_status     r_out_status, n_out_status;
    skt_pkg::t_out_pos    r_out_pos,    n_out_pos;
    skt_pkg::t_out_cnt    r_out_cnt,    n_out_cnt;

    // RAM port
    logic                 ram_we;
    skt_pkg::t_addr       ram_waddr;
    skt_pkg::t_key        ram_wdata;
    skt_pkg::t_addr       ram_raddr;
    skt_pkg::t_key        ram_rdata;

    skt_pkg::t_cmp_res    cmp;

    logic                 cmd_acc;
    skt_pkg::t_cmpw       pos_x;
    skt_pkg::t_cmpw       cnt_x;
    skt_pkg::t_cmpw       depth_x;
    skt_pkg::t_cnt        cnt_m1;
    skt_pkg::t_cnt        pos_c;
    logic [skt_pkg::CW:0] mid_sum;
    skt_pkg::t_cnt        mid;
    skt_pkg::t_cnt        shift_wa;
    logic                 hit;
    logic                 go_up;
    skt_pkg::t_cnt        go_up_w;

    skt_ram #(
        .P_WIDTH (skt_pkg::KEY_WIDTH),
        .P_DEPTH (skt_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    skt_cmp u_cmp (
        .i_desc (r_sort_desc),
        .i_a    (ram_rdata),
        .i_b    (r_key),
        .o_res  (cmp)
    );

    assign i_cmd.ready           = (r_state == S_IDLE);
    assign cmd_acc               = i_cmd.valid && i_cmd.ready;
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.result_position = r_out_pos;
    assign o_rsp.entry_count_out = r_out_cnt;

    assign pos_x   = skt_pkg::t_cmpw'(i_cmd.position);
    assign cnt_x   = skt_pkg::t_cmpw'(r_count);
    assign depth_x = skt_pkg::t_cmpw'(skt_pkg::DEPTH);
    assign pos_c   = skt_pkg::t_cnt'(i_cmd.position);
    assign cnt_m1  = r_count - skt_pkg::t_cnt'(1);
    // floor((lo + hi) / 2) with hi = hiex - 1, valid while lo < hiex
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hiex} - {{skt_pkg::CW{1'b0}}, 1'b1};
    assign mid     = mid_sum[skt_pkg::CW:1];
    assign shift_wa = r_up ? (r_rd_idx + skt_pkg::t_cnt'(1)) : (r_rd_idx - skt_pkg::t_cnt'(1));
    assign hit     = (r_cmd == skt_pkg::CMD_FIND) ? cmp.eq : cmp.after;

    // config port
    always_comb begin
        n_search_mode = r_search_mode;
        n_sort_desc   = r_sort_desc;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                skt_pkg::CFG_SEARCH_MODE: n_search_mode = i_cfg_data;
                skt_pkg::CFG_SORT_DESC:   n_sort_desc   = i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_idx        = r_idx;
        n_rd_idx     = r_rd_idx;
        n_where      = r_where;
        n_lo         = r_lo;
        n_hiex       = r_hiex;
        n_status     = r_status;
        n_bphase     = r_bphase;
        n_up         = r_up;
        n_issue_done = r_issue_done;
        n_rd_valid   = 1'b0;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_cnt    = r_out_cnt;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = r_key;
        ram_raddr    = '0;
        go_up        = 1'b0;
        go_up_w      = r_count;

        unique case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    n_cmd    = i_cmd.command;
                    n_key    = skt_pkg::t_key'(i_cmd.key);
                    n_status = skt_pkg::ST_OK;
                    n_where  = '0;
                    n_state  = S_DONE;
                    unique case (i_cmd.command)
                        skt_pkg::CMD_INSERT_AT: begin
                            if (pos_x >= depth_x) begin
                                n_status = skt_pkg::ST_BAD_POS;
                            end else if (cnt_x >= depth_x) begin
                                n_status = skt_pkg::ST_FULL;
                            end else begin
                                go_up   = 1'b1;
                                go_up_w = (pos_x >= cnt_x) ? r_count : pos_c;
                            end
                        end
                        skt_pkg::CMD_SORTED_INSERT: begin
                            if (cnt_x >= depth_x) begin
                                n_status = skt_pkg::ST_FULL;
                            end else if (r_count == '0) begin
                                go_up = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        skt_pkg::CMD_REMOVE: begin
                            if (pos_x >= cnt_x) begin
                                n_status = skt_pkg::ST_BAD_POS;
                            end else begin
                                n_where      = pos_c;
                                n_up         = 1'b0;
                                n_idx        = pos_c + skt_pkg::t_cnt'(1);
                                n_issue_done = ((pos_c + skt_pkg::t_cnt'(1)) == r_count);
                                n_state      = S_SHIFT;
                            end
                        end
                        skt_pkg::CMD_FIND: begin
                            if (r_count == '0) begin
                                n_status = skt_pkg::ST_NOT_FOUND;
                            end else if (r_search_mode) begin
                                n_bphase = BP_FIRST;
                                n_state  = S_BIN;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        skt_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: ;
                    endcase
                end
            end

            // one read per cycle, each compare in the cycle after its read
            S_SCAN: begin
                if (r_idx < r_count) begin
                    ram_raddr  = r_idx[skt_pkg::AW-1:0];
                    n_idx      = r_idx + skt_pkg::t_cnt'(1);
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_idx;
                end
                if (r_rd_valid) begin
                    if (hit) begin
                        if (r_cmd == skt_pkg::CMD_FIND) begin
                            n_where = r_rd_idx;
                            n_state = S_DONE;
                        end else begin
                            go_up   = 1'b1;
                            go_up_w = r_rd_idx;
                        end
                    end else if (r_rd_idx == cnt_m1) begin
                        if (r_cmd == skt_pkg::CMD_FIND) begin
                            n_status = skt_pkg::ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            go_up   = 1'b1;
                            go_up_w = r_count;
                        end
                    end
                end
            end

            // each probe reads a key, then compares it; the next read waits for the compare
            S_BIN: begin
                if (!r_rd_valid) begin
                    unique case (r_bphase)
                        BP_FIRST: begin
                            ram_raddr  = '0;
                            n_rd_valid = 1'b1;
                        end
                        BP_LAST: begin
                            ram_raddr  = cnt_m1[skt_pkg::AW-1:0];
                            n_rd_valid = 1'b1;
                        end
                        BP_LOOP: begin
                            if (r_lo < r_hiex) begin
                                ram_raddr  = mid[skt_pkg::AW-1:0];
                                n_rd_valid = 1'b1;
                                n_rd_idx   = mid;
                            end else begin
                                n_status = skt_pkg::ST_NOT_FOUND;
                                n_state  = S_DONE;
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    unique case (r_bphase)
                        BP_FIRST: begin
                            if (cmp.after) begin
                                n_status = skt_pkg::ST_NOT_FOUND;
                                n_state  = S_DONE;
                            end else begin
                                n_bphase = BP_LAST;
                            end
                        end
                        BP_LAST: begin
                            if (cmp.precedes) begin
                                n_status = skt_pkg::ST_NOT_FOUND;
                                n_state  = S_DONE;
                            end else begin
                                n_bphase = BP_LOOP;
                                n_lo     = '0;
                                n_hiex   = r_count;
                            end
                        end
                        BP_LOOP: begin
                            if (cmp.eq) begin
                                n_where = r_rd_idx;
                                n_state = S_DONE;
                            end else if (cmp.precedes) begin
                                n_lo = r_rd_idx + skt_pkg::t_cnt'(1);
                            end else begin
                                n_hiex = r_rd_idx;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // move one key per cycle; insert then drops the new key in the gap
            S_SHIFT: begin
                if (!r_issue_done) begin
                    ram_raddr  = r_idx[skt_pkg::AW-1:0];
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_idx;
                    if (r_up) begin
                        if (r_idx == r_where) begin
                            n_issue_done = 1'b1;
                        end else begin
                            n_idx = r_idx - skt_pkg::t_cnt'(1);
                        end
                    end else begin
                        if (r_idx == cnt_m1) begin
                            n_issue_done = 1'b1;
                        end else begin
                            n_idx = r_idx + skt_pkg::t_cnt'(1);
                        end
                    end
                end
                if (r_rd_valid) begin
                    ram_we    = 1'b1;
                    ram_waddr = shift_wa[skt_pkg::AW-1:0];
                    ram_wdata = ram_rdata;
                end else if (r_issue_done) begin
                    if (r_up) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_where[skt_pkg::AW-1:0];
                        ram_wdata = r_key;
                        n_count   = r_count + skt_pkg::t_cnt'(1);
                    end else begin
                        n_count   = cnt_m1;
                    end
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_pos    = (r_status == skt_pkg::ST_OK) ?
                                   skt_pkg::t_out_pos'(r_where) : '0;
                    n_out_cnt    = skt_pkg::t_out_cnt'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // open a gap at go_up_w (append when it equals the count)
        if (go_up) begin
            n_where      = go_up_w;
            n_up         = 1'b1;
            n_idx        = cnt_m1;
            n_issue_done = (go_up_w == r_count);
            n_rd_valid   = 1'b0;
            n_state      = S_SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
            r_rd_valid    <= 1'b0;
            r_search_mode <= 1'b0;
            r_sort_desc   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_out_valid   <= n_out_valid;
            r_rd_valid    <= n_rd_valid;
            r_search_mode <= n_search_mode;
            r_sort_desc   <= n_sort_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_rd_idx     <= n_rd_idx;
        r_where      <= n_where;
        r_lo         <= n_lo;
        r_hiex       <= n_hiex;
        r_status     <= n_status;
        r_bphase     <= n_bphase;
        r_up         <= n_up;
        r_issue_done <= n_issue_done;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_cnt    <= n_out_cnt;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= skt_pkg::t_cnt'(skt_pkg::DEPTH))
        else $error("entry count beyond table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |=> (r_state != S_IDLE))
        else $error("sequencer idle right after a command transaction");

    a_shift_moves_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && n_state == S_DONE) |=> (r_count != $past(r_count)))
        else $error("shift finished without changing the entry count");

    a_bin_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIN && r_bphase == BP_LOOP) |-> (r_hiex <= r_count))
        else $error("binary search bound beyond entry count");

endmodule

`default_nettype wire
